// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ncp_pkg.sv -----
// Types and constants of the nested call profiler.
package ncp_pkg;

  localparam int unsigned REC_W  = 10;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned CNT_W  = 32;

  localparam logic CMD_ENTER = 1'b0;
  localparam logic CMD_EXIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic {
    PH_IDLE,
    PH_EXEC
  } phase_t;

  typedef struct packed {
    logic              cmd;
    logic [REC_W-1:0]  record;
    logic              is_new;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] start_time;
  } req_t;

  typedef struct packed {
    logic [REC_W-1:0]  record_out;
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  call_count;
    logic [TIME_W-1:0] total_time;
    logic [TIME_W-1:0] self_time;
    status_t           status;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] total;
    logic [TIME_W-1:0] excl;
  } rec_entry_t;

endpackage

// ----- rtl/core/nested_call_profiler.sv -----
// Nested call profiler: record table and child-time stack in synchronous RAM.
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_t  (cmd, record, is_new, now, start_time)
//  rsp      out  rsp_valid/rsp_stall   rsp_t  (record_out .. status)
//
//  Each beat first reads the record and stack RAMs, then updates and writes
//  back. One event is in flight at a time; the single-port RAM access sets this.
//  Reset clears the stack pointer, record count and the bottom child sum; no RAM sweep.
//  A stalled result holds in the output register; the update waits until it is taken.
module nested_call_profiler
  import ncp_pkg::*;
#(
  parameter int unsigned RECORDS     = 1024,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned AW  = $clog2(RECORDS);
  localparam int unsigned RUW = $clog2(RECORDS + 1);
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned STW = $clog2(STACK_DEPTH + 1);

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  phase_t phase, phase_next;
  logic   accept, commit;

  logic [RUW-1:0]    records_used;
  logic [STW-1:0]    stack_top;
  logic [TIME_W-1:0] top_sum;

  // captured event
  logic              cmd_q, is_new_q;
  logic [REC_W-1:0]  rec_out_q;
  logic [AW-1:0]     addr_q;
  logic [TIME_W-1:0] now_q, elapsed_q, excl_inc_q;
  status_t           status_q;

  rec_entry_t        tbl_mem [RECORDS];
  rec_entry_t        tbl_rd;
  logic [TIME_W-1:0] stk_mem [STACK_DEPTH];
  logic [TIME_W-1:0] stk_rd;

  logic [31:0]       rec_wide, used_wide, top_wide, top_m1;
  logic [AW-1:0]     addr_d;
  logic [SAW-1:0]    stk_raddr, stk_waddr;
  logic [REC_W-1:0]  rec_out_d;
  status_t           status_d;
  logic [TIME_W-1:0] elapsed_d, excl_inc_d;
  logic [TIME_W:0]   diff;

  rec_entry_t        base, entry_next;
  logic [TIME_W-1:0] parent_next;
  rsp_t              rsp_d;

  always_comb begin
    unique case (phase)
      PH_IDLE: phase_next = req_valid ? PH_EXEC : PH_IDLE;
      PH_EXEC: phase_next = commit ? PH_IDLE : PH_EXEC;
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (phase != PH_IDLE);
    accept    = req_valid && !req_stall;
    commit    = (phase == PH_EXEC) && (!rsp_valid || !rsp_stall);
  end

  // checks and addresses on the incoming beat
  always_comb begin
    rec_wide   = 32'(req.record);
    used_wide  = 32'(records_used);
    top_wide   = 32'(stack_top);
    top_m1     = top_wide - 32'd1;
    stk_raddr  = top_m1[SAW-1:0];
    stk_waddr  = top_wide[SAW-1:0];
    elapsed_d  = req.now - req.start_time;
    diff       = {1'b0, elapsed_d} - {1'b0, top_sum};
    excl_inc_d = diff[TIME_W] ? '0 : diff[TIME_W-1:0];
    addr_d     = rec_wide[AW-1:0];
    rec_out_d  = req.record;
    status_d   = ST_OK;
    if (req.cmd == CMD_ENTER) begin
      if (req.is_new) begin
        addr_d    = used_wide[AW-1:0];
        rec_out_d = used_wide[REC_W-1:0];
        if (used_wide >= 32'(RECORDS)) status_d = ST_FULL;
      end else if (rec_wide >= used_wide) begin
        status_d = ST_UNKNOWN;
      end
      if (status_d == ST_OK && top_wide >= 32'(STACK_DEPTH)) status_d = ST_OVERFLOW;
    end else begin
      if (stack_top == '0) begin
        status_d = ST_UNDERFLOW;
      end else if (rec_wide >= used_wide) begin
        status_d = ST_UNKNOWN;
      end
    end
  end

  // update of the record and the parent sum
  always_comb begin
    base        = (cmd_q == CMD_ENTER && is_new_q) ? '0 : tbl_rd;
    entry_next  = base;
    parent_next = sat_add(stk_rd, elapsed_q);
    if (cmd_q == CMD_ENTER) begin
      entry_next.count = (base.count == '1) ? base.count : base.count + CNT_W'(1);
    end else begin
      entry_next.total = sat_add(base.total, elapsed_q);
      entry_next.excl  = sat_add(base.excl, excl_inc_q);
    end
    rsp_d            = '0;
    rsp_d.record_out = rec_out_q;
    rsp_d.status     = status_q;
    if (status_q == ST_OK) begin
      rsp_d.stamp      = (cmd_q == CMD_ENTER) ? now_q : '0;
      rsp_d.call_count = entry_next.count;
      rsp_d.total_time = entry_next.total;
      rsp_d.self_time  = entry_next.excl;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) tbl_rd <= tbl_mem[addr_d];
    if (commit && status_q == ST_OK) tbl_mem[addr_q] <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (accept) stk_rd <= stk_mem[stk_raddr];
    if (commit && status_q == ST_OK && cmd_q == CMD_ENTER) stk_mem[stk_waddr] <= top_sum;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= req.cmd;
      is_new_q   <= req.is_new;
      rec_out_q  <= rec_out_d;
      addr_q     <= addr_d;
      now_q      <= req.now;
      elapsed_q  <= elapsed_d;
      excl_inc_q <= excl_inc_d;
      status_q   <= status_d;
    end
    if (commit) rsp <= rsp_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      rsp_valid    <= 1'b0;
      records_used <= '0;
      stack_top    <= '0;
      top_sum      <= '0;
    end else begin
      phase <= phase_next;
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (commit && status_q == ST_OK) begin
        if (cmd_q == CMD_ENTER) begin
          stack_top <= stack_top + STW'(1);
          top_sum   <= '0;
          if (is_new_q) records_used <= records_used + RUW'(1);
        end else begin
          stack_top <= stack_top - STW'(1);
          top_sum   <= parent_next;
        end
      end
    end
  end

endmodule

// ----- rtl/core/ncp_checker.sv -----
// Port-level checks for the nested call profiler, bound to the profiler module.
`include "assert_macros.svh"

module ncp_checker
  import ncp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // one event in flight: busy after each beat
  `ASSERT_NXT(a_busy_after_beat, clk, rst, req_valid && !req_stall, req_stall)

  `ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // a new result only follows a busy cycle
  `ASSERT_IMP(a_rsp_after_work, clk, rst, $rose(rsp_valid), $past(req_stall))

  `ASSERT_IMP(a_err_zero, clk, rst, rsp_valid && rsp.status != ST_OK, rsp.stamp == '0 && rsp.call_count == '0 && rsp.total_time == '0 && rsp.self_time == '0)

  `ASSERT_IMP(a_self_le_total, clk, rst, rsp_valid && rsp.status == ST_OK, rsp.self_time <= rsp.total_time)

endmodule

bind nested_call_profiler ncp_checker u_ncp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- tb/sv/nested_call_profiler_test.sv -----
// Self-checking testbench of the nested call profiler: enter/exit beats against a predictor.
module nested_call_profiler_test;
  import ncp_pkg::*;

  localparam int unsigned RECORDS      = 1024;
  localparam int unsigned STACK_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT  = 60000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 200;
  localparam logic [TIME_W-1:0] T_MAX  = '1;

  typedef struct {
    logic [REC_W-1:0]  rec;
    logic [TIME_W-1:0] stamp;
  } frame_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  nested_call_profiler #(
    .RECORDS    (RECORDS),
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // predicted profiler state
  logic [CNT_W-1:0]  calls_tbl [RECORDS];
  logic [TIME_W-1:0] incl_tbl  [RECORDS];
  logic [TIME_W-1:0] excl_tbl  [RECORDS];
  logic [TIME_W-1:0] child_sum [STACK_DEPTH+1];
  int unsigned       nest_depth    = 0;
  int unsigned       records_alloc = 0;

  rsp_t        stats_due [$];
  frame_t      open_frames [$];
  logic [TIME_W-1:0] clock_ts = '0;

  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 59;
  logic        holding       = 1'b0;
  event        hold_go;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;

  initial begin
    child_sum[0] = '0;
  end

  initial forever #2 clk = ~clk;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? T_MAX : s[TIME_W-1:0];
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic logic [TIME_W-1:0] advance_clock();
    if ($urandom_range(49) == 0)
      clock_ts += rand_time();
    else
      clock_ts += TIME_W'($urandom_range(1, 5000));
    return clock_ts;
  endfunction

  function automatic logic [REC_W-1:0] known_record();
    if (records_alloc == 0)
      return REC_W'($urandom);
    return REC_W'($urandom_range(records_alloc - 1));
  endfunction

  function automatic req_t make_req(input logic cmd, input logic [REC_W-1:0] rec,
                                    input logic is_new, input logic [TIME_W-1:0] now_v,
                                    input logic [TIME_W-1:0] start_v);
    req_t r;
    r.cmd        = cmd;
    r.record     = rec;
    r.is_new     = is_new;
    r.now        = now_v;
    r.start_time = start_v;
    return r;
  endfunction

  task automatic account_event(input req_t ev);
    rsp_t              r;
    frame_t            fr;
    int unsigned       idx;
    logic [TIME_W-1:0] elapsed;
    r            = '0;
    r.record_out = ev.record;
    r.status     = ST_OK;
    idx          = ev.record;
    if (ev.cmd == CMD_ENTER) begin
      if (ev.is_new) idx = records_alloc;
      if (ev.is_new && records_alloc >= RECORDS) begin
        r.record_out = REC_W'(records_alloc);
        r.status     = ST_FULL;
      end else if (!ev.is_new && idx >= records_alloc) begin
        r.status = ST_UNKNOWN;
      end else if (nest_depth >= STACK_DEPTH) begin
        r.record_out = REC_W'(idx);
        r.status     = ST_OVERFLOW;
      end else begin
        if (ev.is_new) begin
          calls_tbl[idx] = '0;
          incl_tbl[idx]  = '0;
          excl_tbl[idx]  = '0;
          records_alloc++;
        end
        if (calls_tbl[idx] != '1) calls_tbl[idx]++;
        nest_depth++;
        child_sum[nest_depth] = '0;
        r.record_out = REC_W'(idx);
        r.stamp      = ev.now;
        r.call_count = calls_tbl[idx];
        r.total_time = incl_tbl[idx];
        r.self_time  = excl_tbl[idx];
        fr.rec       = REC_W'(idx);
        fr.stamp     = ev.now;
        open_frames.push_back(fr);
      end
    end else if (nest_depth == 0) begin
      r.status = ST_UNDERFLOW;
    end else if (idx >= records_alloc) begin
      r.status = ST_UNKNOWN;
    end else begin
      elapsed = ev.now - ev.start_time;
      incl_tbl[idx] = sat_add(incl_tbl[idx], elapsed);
      if (elapsed > child_sum[nest_depth])
        excl_tbl[idx] = sat_add(excl_tbl[idx], elapsed - child_sum[nest_depth]);
      nest_depth--;
      child_sum[nest_depth] = sat_add(child_sum[nest_depth], elapsed);
      r.call_count = calls_tbl[idx];
      r.total_time = incl_tbl[idx];
      r.self_time  = excl_tbl[idx];
      void'(open_frames.pop_back());
    end
    stats_due.push_back(r);
  endtask

  task automatic send_event(input req_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= ev;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    account_event(ev);
  endtask

  task automatic enter_region(input logic alloc, input logic [REC_W-1:0] rec);
    send_event(make_req(CMD_ENTER, rec, alloc, advance_clock(), rand_time()));
  endtask

  task automatic leave_region();
    frame_t fr;
    fr = open_frames[$];
    send_event(make_req(CMD_EXIT, fr.rec, 1'($urandom), advance_clock(), fr.stamp));
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_REPORTS)
      $display("cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (stats_due.size() == 0) begin
        report_mismatch("unexpected beat, record_out", 64'(rsp.record_out), '0);
      end else begin
        exp_r = stats_due.pop_front();
        if (rsp.record_out !== exp_r.record_out)
          report_mismatch("record_out", 64'(rsp.record_out), 64'(exp_r.record_out));
        if (rsp.stamp !== exp_r.stamp)
          report_mismatch("stamp", 64'(rsp.stamp), 64'(exp_r.stamp));
        if (rsp.call_count !== exp_r.call_count)
          report_mismatch("call_count", 64'(rsp.call_count), 64'(exp_r.call_count));
        if (rsp.total_time !== exp_r.total_time)
          report_mismatch("total_time", 64'(rsp.total_time), 64'(exp_r.total_time));
        if (rsp.self_time !== exp_r.self_time)
          report_mismatch("self_time", 64'(rsp.self_time), 64'(exp_r.self_time));
        if (rsp.status !== exp_r.status)
          report_mismatch("status", 64'(rsp.status), 64'(exp_r.status));
      end
    end
  end

  always @(posedge clk) begin
    rsp_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  // long receiver hold-off, so the block backs up into its input
  initial forever begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    send_event(make_req(CMD_EXIT, '1, 1'b1, T_MAX, T_MAX));
    send_event(make_req(CMD_ENTER, '0, 1'b0, T_MAX, '0));
    send_event(make_req(CMD_ENTER, '1, 1'b0, '0, T_MAX));
    send_event(make_req(CMD_ENTER, 10'h2aa, 1'b1, '0, T_MAX));
    send_event(make_req(CMD_ENTER, 10'h155, 1'b1, T_MAX, '0));
    // elapsed across timestamp wrap
    send_event(make_req(CMD_EXIT, 10'd1, 1'b0, 48'd5, T_MAX));
    send_event(make_req(CMD_EXIT, 10'd7, 1'b0, 48'd10, '0));
    send_event(make_req(CMD_ENTER, 10'd1, 1'b0, 48'd100, '0));
    send_event(make_req(CMD_EXIT, 10'd1, 1'b0, 48'd1100, 48'd100));
    // child time exceeds elapsed, self time floored
    send_event(make_req(CMD_EXIT, 10'd0, 1'b1, 48'd50, '0));
    // saturation of totals, self times and child sums
    send_event(make_req(CMD_ENTER, 10'd0, 1'b0, '0, '0));
    send_event(make_req(CMD_ENTER, 10'd1, 1'b0, '0, '0));
    send_event(make_req(CMD_EXIT, 10'd1, 1'b0, T_MAX, '0));
    send_event(make_req(CMD_ENTER, 10'd1, 1'b0, '0, '0));
    send_event(make_req(CMD_EXIT, 10'd1, 1'b0, T_MAX, '0));
    send_event(make_req(CMD_EXIT, 10'd0, 1'b0, T_MAX, '0));
    send_event(make_req(CMD_ENTER, 10'd0, 1'b0, 48'd7, '0));
    send_event(make_req(CMD_EXIT, 10'd0, 1'b0, 48'd7, 48'd7));
  endtask

  task automatic test_random_mix(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 12)
        send_event(make_req(1'($urandom), REC_W'($urandom), 1'($urandom),
                            rand_time(), rand_time()));
      else if (roll < 17 && open_frames.size() != 0)
        send_event(make_req(CMD_EXIT, known_record(), 1'b0, advance_clock(), rand_time()));
      else if (open_frames.size() == 0 || (nest_depth < STACK_DEPTH && roll < 60))
        enter_region($urandom_range(99) < 20 || records_alloc == 0, known_record());
      else
        leave_region();
    end
  endtask

  task automatic test_backpressure();
    -> hold_go;
    test_random_mix(40);
  endtask

  task automatic test_stack_overflow();
    while (nest_depth < STACK_DEPTH) enter_region(records_alloc < RECORDS, known_record());
    enter_region(1'b0, known_record());
    enter_region(1'b1, REC_W'($urandom));
    send_event(make_req(CMD_ENTER, REC_W'(records_alloc), 1'b0, advance_clock(), '0));
  endtask

  task automatic test_table_fill();
    while (records_alloc < RECORDS) begin
      if (nest_depth >= STACK_DEPTH) leave_region();
      enter_region(1'b1, REC_W'($urandom));
    end
    repeat (3) enter_region(1'b1, REC_W'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(100);
    test_backpressure();
    test_stack_overflow();
    send_idle_pct = 59;
    recv_idle_pct = 35;
    test_random_mix(50);
    test_table_fill();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(100);
    req_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
